// File: rtl/cia_pkg.sv
// cone isolation accumulator: shared types, codes and constants
// used by cone_isolation_accumulator; depends on nothing else
`default_nettype none

package cia_pkg;

	// default widths of the angle, pt and sum datapaths
	localparam int DEF_ANGLE_BITS = 12;
	localparam int DEF_PT_BITS    = 16;
	localparam int DEF_SUM_BITS   = 24;

	// result field width on the output stream
	localparam int OUT_BITS    = 24;
	localparam int OUT_FIELDS_W = 4 * OUT_BITS;
	localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	// configuration register widths
	localparam int DR_CFG_W   = 27;
	localparam int PT_CFG_W   = 16;
	localparam int MODE_W     = 2;
	localparam int BETA_W     = 9;
	localparam int BETA_FRAC  = 8;
	localparam int CFG_DATA_W = 27;
	localparam int CFG_IDX_W  = 3;

	// configuration reset values
	localparam logic [DR_CFG_W-1:0] RST_MIN_DR_SQ      = DR_CFG_W'(0);
	localparam logic [DR_CFG_W-1:0] RST_MAX_DR_SQ      = DR_CFG_W'(38000);
	localparam logic [MODE_W-1:0]   RST_ISO_MODE       = MODE_W'(0);
	localparam logic [PT_CFG_W-1:0] RST_MIN_NEUTRAL_PT = PT_CFG_W'(32);
	localparam logic [PT_CFG_W-1:0] RST_MIN_PILEUP_PT  = PT_CFG_W'(32);
	localparam logic [BETA_W-1:0]   RST_BETA_WEIGHT    = BETA_W'(128);

	// isolation modes, other codes are errors
	localparam logic [MODE_W-1:0] MODE_CHARGED    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELTA_BETA = 2'd1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DR_SQ      = 3'd0,
		REG_MAX_DR_SQ      = 3'd1,
		REG_ISO_MODE       = 3'd2,
		REG_MIN_NEUTRAL_PT = 3'd3,
		REG_MIN_PILEUP_PT  = 3'd4,
		REG_BETA_WEIGHT    = 3'd5
	} cfg_reg_t;

	// input item kind carried on tuser
	typedef enum logic {
		REQ_REFERENCE = 1'b0,
		REQ_CANDIDATE = 1'b1
	} req_kind_t;

	// which sum a candidate goes into
	typedef enum logic [1:0] {
		ADD_NONE    = 2'd0,
		ADD_CHARGED = 2'd1,
		ADD_NEUTRAL = 2'd2,
		ADD_PILEUP  = 2'd3
	} add_sel_t;

endpackage

`default_nettype wire

// File: rtl/cone_isolation_accumulator.sv
// cone isolation accumulator top level: cone test, pt sums, delta-beta result
// depends on cia_pkg
`default_nettype none

// Usage
// A reference item (s_tuser = 0) loads the eta and phi of the particle under
// study and clears the charged, neutral and pile-up sums. Candidate items
// (s_tuser = 1) follow; each one that is not the particle itself and lies in
// the ring between the inner and outer cone radius adds its pt to at most one
// sum. The candidate with s_tlast set ends the run: one result transfer carries
// isolation and the three sums, the sums are cleared. Configuration registers
// are written through cfg_we/cfg_index/cfg_wdata while no item is in flight.
// Timing: one input transfer per cycle is taken while s_tready is high. The
// pipeline has seven register stages (input, squares, cone test, sums, beta
// product, delta-beta term, output), and the result of a last candidate passes
// through them in that order to m_tvalid. The result stages hold up to four
// results; a stalled m_tready only holds the input back once they are full
// and another last candidate reaches the sum stage.
// Reset: arst_n clears all valid bits and the sums and loads the register
// reset values; reference eta and phi start at zero.
module cone_isolation_accumulator #(
	parameter int ANGLE_BITS = cia_pkg::DEF_ANGLE_BITS,
	parameter int PT_BITS    = cia_pkg::DEF_PT_BITS,
	parameter int SUM_BITS   = cia_pkg::DEF_SUM_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// input stream
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// coord_eta, coord_phi, trans_momentum, is_charged, vertex_assoc, is_self
	input  wire logic [((2*ANGLE_BITS+PT_BITS+5+7)/8)*8-1:0] s_tdata,
	// req_type
	input  wire logic                                  s_tuser,
	// last_cand
	input  wire logic                                  s_tlast,
	// result stream
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// isolation, charged_total, neutral_total, pileup_total
	output logic [cia_pkg::OUT_TDATA_W-1:0]            m_tdata,
	// mode_error
	output logic                                       m_tuser,
	// configuration writes
	input  wire logic                                  cfg_we,
	input  wire logic [cia_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [cia_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import cia_pkg::*;

	localparam int ETA_W   = ANGLE_BITS + 1;
	localparam int DETA_W  = ANGLE_BITS + 2;
	localparam int ESQ_W   = 2 * DETA_W;
	localparam int PSQ_W   = 2 * ANGLE_BITS;
	localparam int DR_W    = ESQ_W + 1;
	localparam int DRC_W   = (DR_W > DR_CFG_W) ? DR_W : DR_CFG_W;
	localparam int PTC_W   = (PT_BITS > PT_CFG_W) ? PT_BITS : PT_CFG_W;
	localparam int ACC_W   = ((SUM_BITS > PT_BITS) ? SUM_BITS : PT_BITS) + 1;
	localparam int PLUS_W  = SUM_BITS + BETA_FRAC;
	localparam int MINUS_W = SUM_BITS + BETA_W;
	localparam int PHI_LO  = ETA_W;
	localparam int PT_LO   = PHI_LO + ANGLE_BITS;
	localparam int CHG_POS = PT_LO + PT_BITS;
	localparam int VTX_LO  = CHG_POS + 1;
	localparam int SELF_POS = VTX_LO + 2;

	localparam logic [ACC_W-1:0] ACC_MAX =
		{{(ACC_W-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};
	localparam logic [SUM_BITS:0] ISO_MAX = {1'b0, {SUM_BITS{1'b1}}};

	// configuration registers
	logic [DR_CFG_W-1:0] min_dr_sq_q, max_dr_sq_q;
	logic [MODE_W-1:0]   iso_mode_q;
	logic [PT_CFG_W-1:0] min_neutral_pt_q, min_pileup_pt_q;
	logic [BETA_W-1:0]   beta_weight_q;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dr_sq_q      <= RST_MIN_DR_SQ;
			max_dr_sq_q      <= RST_MAX_DR_SQ;
			iso_mode_q       <= RST_ISO_MODE;
			min_neutral_pt_q <= RST_MIN_NEUTRAL_PT;
			min_pileup_pt_q  <= RST_MIN_PILEUP_PT;
			beta_weight_q    <= RST_BETA_WEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_DR_SQ:      min_dr_sq_q      <= cfg_wdata[DR_CFG_W-1:0];
				REG_MAX_DR_SQ:      max_dr_sq_q      <= cfg_wdata[DR_CFG_W-1:0];
				REG_ISO_MODE:       iso_mode_q       <= cfg_wdata[MODE_W-1:0];
				REG_MIN_NEUTRAL_PT: min_neutral_pt_q <= cfg_wdata[PT_CFG_W-1:0];
				REG_MIN_PILEUP_PT:  min_pileup_pt_q  <= cfg_wdata[PT_CFG_W-1:0];
				REG_BETA_WEIGHT:    beta_weight_q    <= cfg_wdata[BETA_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline valid bits and payload
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_v_q;

	req_kind_t                kind_s1, kind_s2, kind_s3;
	logic signed [ETA_W-1:0]  eta_s1;
	logic [ANGLE_BITS-1:0]    phi_s1;
	logic [PT_BITS-1:0]       pt_s1, pt_s2, pt_s3;
	logic                     chg_s1, chg_s2;
	logic [1:0]               vtx_s1, vtx_s2;
	logic                     self_s1, self_s2;
	logic                     last_s1, last_s2, last_s3;
	logic [ESQ_W-1:0]         eta_sq_s2;
	logic [PSQ_W-1:0]         phi_sq_s2;
	add_sel_t                 sel_s3;

	logic signed [ETA_W-1:0]  ref_eta_q;
	logic [ANGLE_BITS-1:0]    ref_phi_q;
	logic [SUM_BITS-1:0]      chg_acc_q, neu_acc_q, pu_acc_q;

	logic [SUM_BITS-1:0]      chg_s4, neu_s4, pu_s4;
	logic [SUM_BITS-1:0]      chg_s5, neu_s5, pu_s5;
	logic [PLUS_W-1:0]        plus_s5;
	logic [MINUS_W-1:0]       minus_s5;
	logic [SUM_BITS-1:0]      chg_s6, neu_s6, pu_s6, term_s6;
	logic [OUT_BITS-1:0]      iso_q, chg_out_q, neu_out_q, pu_out_q;
	logic                     err_q;

	// backpressure chain, the sum stage only waits when it holds a last candidate
	logic out_rdy, rdy6, rdy5, rdy4, rdy3, rdy2, rdy1;
	logic res_s3, go3;

	assign out_rdy = !out_v_q || m_tready;
	assign rdy6    = !v_s6 || out_rdy;
	assign rdy5    = !v_s5 || rdy6;
	assign rdy4    = !v_s4 || rdy5;
	assign res_s3  = (kind_s3 == REQ_CANDIDATE) && last_s3;
	assign go3     = v_s3 && (!res_s3 || rdy4);
	assign rdy3    = !v_s3 || go3;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1    <= s_tvalid;
			if (rdy2)    v_s2    <= v_s1;
			if (rdy3)    v_s3    <= v_s2;
			if (rdy4)    v_s4    <= go3 && res_s3;
			if (rdy5)    v_s5    <= v_s4;
			if (rdy6)    v_s6    <= v_s5;
			if (out_rdy) out_v_q <= v_s6;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			kind_s1 <= req_kind_t'(s_tuser);
			eta_s1  <= s_tdata[ETA_W-1:0];
			phi_s1  <= s_tdata[PHI_LO +: ANGLE_BITS];
			pt_s1   <= s_tdata[PT_LO +: PT_BITS];
			chg_s1  <= s_tdata[CHG_POS];
			vtx_s1  <= s_tdata[VTX_LO +: 2];
			self_s1 <= s_tdata[SELF_POS];
			last_s1 <= s_tlast;
		end
	end

	// reference particle, updated as the reference item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_eta_q <= '0;
			ref_phi_q <= '0;
		end else if (v_s1 && rdy2 && kind_s1 == REQ_REFERENCE) begin
			ref_eta_q <= eta_s1;
			ref_phi_q <= phi_s1;
		end
	end

	// angle differences with phi wrap, then squares
	logic signed [DETA_W-1:0]     deta;
	logic signed [ANGLE_BITS-1:0] dphi;
	logic signed [ESQ_W-1:0]      eta_prod;
	logic signed [PSQ_W-1:0]      phi_prod;

	assign deta     = DETA_W'(eta_s1) - DETA_W'(ref_eta_q);
	assign dphi     = phi_s1 - ref_phi_q;
	assign eta_prod = deta * deta;
	assign phi_prod = dphi * dphi;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			kind_s2   <= kind_s1;
			eta_sq_s2 <= eta_prod;
			phi_sq_s2 <= phi_prod;
			pt_s2     <= pt_s1;
			chg_s2    <= chg_s1;
			vtx_s2    <= vtx_s1;
			self_s2   <= self_s1;
			last_s2   <= last_s1;
		end
	end

	// stage 2: cone test and choice of sum
	logic [DRC_W-1:0] dr;
	logic             in_cone;
	logic             neu_pass, pu_pass;
	add_sel_t         sel;

	assign dr       = DRC_W'(eta_sq_s2) + DRC_W'(phi_sq_s2);
	assign in_cone  = (dr >= DRC_W'(min_dr_sq_q)) && (dr <= DRC_W'(max_dr_sq_q));
	assign neu_pass = PTC_W'(pt_s2) > PTC_W'(min_neutral_pt_q);
	assign pu_pass  = PTC_W'(pt_s2) > PTC_W'(min_pileup_pt_q);

	always_comb begin
		sel = ADD_NONE;
		if (kind_s2 == REQ_CANDIDATE && !self_s2 && in_cone) begin
			if (!chg_s2) begin
				if (neu_pass) sel = ADD_NEUTRAL;
			end else if (vtx_s2[1]) begin
				sel = ADD_CHARGED;
			end else if (pu_pass) begin
				sel = ADD_PILEUP;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			kind_s3 <= kind_s2;
			sel_s3  <= sel;
			pt_s3   <= pt_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 3: saturating accumulate into the chosen sum
	logic [ACC_W-1:0]    chg_sum, neu_sum, pu_sum;
	logic [SUM_BITS-1:0] chg_new, neu_new, pu_new;

	assign chg_sum = ACC_W'(chg_acc_q) + ACC_W'(pt_s3);
	assign neu_sum = ACC_W'(neu_acc_q) + ACC_W'(pt_s3);
	assign pu_sum  = ACC_W'(pu_acc_q) + ACC_W'(pt_s3);

	always_comb begin
		chg_new = chg_acc_q;
		neu_new = neu_acc_q;
		pu_new  = pu_acc_q;
		case (sel_s3)
			ADD_CHARGED: chg_new = SUM_BITS'((chg_sum > ACC_MAX) ? ACC_MAX : chg_sum);
			ADD_NEUTRAL: neu_new = SUM_BITS'((neu_sum > ACC_MAX) ? ACC_MAX : neu_sum);
			ADD_PILEUP:  pu_new  = SUM_BITS'((pu_sum > ACC_MAX) ? ACC_MAX : pu_sum);
			default: ;
		endcase
	end

	// sums clear on a reference item and after a last candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_acc_q <= '0;
			neu_acc_q <= '0;
			pu_acc_q  <= '0;
		end else if (go3) begin
			if (kind_s3 == REQ_REFERENCE || last_s3) begin
				chg_acc_q <= '0;
				neu_acc_q <= '0;
				pu_acc_q  <= '0;
			end else begin
				chg_acc_q <= chg_new;
				neu_acc_q <= neu_new;
				pu_acc_q  <= pu_new;
			end
		end
	end

	// stage 4: sums of the finished run
	always_ff @(posedge clk) begin
		if (go3 && res_s3 && rdy4) begin
			chg_s4 <= chg_new;
			neu_s4 <= neu_new;
			pu_s4  <= pu_new;
		end
	end

	// stage 5: scaled neutral sum and beta-weighted pile-up
	always_ff @(posedge clk) begin
		if (rdy5) begin
			chg_s5   <= chg_s4;
			neu_s5   <= neu_s4;
			pu_s5    <= pu_s4;
			plus_s5  <= {neu_s4, {BETA_FRAC{1'b0}}};
			minus_s5 <= MINUS_W'(beta_weight_q) * MINUS_W'(pu_s4);
		end
	end

	// stage 6: delta-beta term, clipped at zero
	logic [MINUS_W-1:0] db_diff;
	logic               db_pos;

	assign db_diff = MINUS_W'(plus_s5) - minus_s5;
	assign db_pos  = MINUS_W'(plus_s5) > minus_s5;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			chg_s6  <= chg_s5;
			neu_s6  <= neu_s5;
			pu_s6   <= pu_s5;
			term_s6 <= db_pos ? db_diff[PLUS_W-1:BETA_FRAC] : '0;
		end
	end

	// output register: isolation per mode
	logic [SUM_BITS:0]   iso_sum;
	logic [SUM_BITS-1:0] iso_val;
	logic                iso_err;

	assign iso_sum = {1'b0, chg_s6} + {1'b0, term_s6};

	always_comb begin
		iso_val = '0;
		iso_err = 1'b0;
		case (iso_mode_q)
			MODE_CHARGED:    iso_val = chg_s6;
			MODE_DELTA_BETA: iso_val = SUM_BITS'((iso_sum > ISO_MAX) ? ISO_MAX : iso_sum);
			default:         iso_err = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			iso_q     <= OUT_BITS'(iso_val);
			chg_out_q <= OUT_BITS'(chg_s6);
			neu_out_q <= OUT_BITS'(neu_s6);
			pu_out_q  <= OUT_BITS'(pu_s6);
			err_q     <= iso_err;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_TDATA_W'({pu_out_q, neu_out_q, chg_out_q, iso_q});
	assign m_tuser  = err_q;

	// sums are empty right after a run hands over its result
	assert property (@(posedge clk) disable iff (!arst_n)
		go3 && res_s3 |=> (chg_acc_q == '0) && (neu_acc_q == '0) && (pu_acc_q == '0))
		else $error("sums not cleared after last candidate");

	// an unknown mode reports zero isolation
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[OUT_BITS-1:0] == '0))
		else $error("isolation nonzero on mode error");

	// charged-only mode gives the charged sum as isolation
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (iso_mode_q == MODE_CHARGED)
		|-> !m_tuser && (m_tdata[OUT_BITS-1:0] == m_tdata[2*OUT_BITS-1:OUT_BITS]))
		else $error("charged mode isolation differs from charged sum");

endmodule

`default_nettype wire

// File: verif/tb_cone_isolation_accumulator.sv
// testbench for cone_isolation_accumulator: queued particle stream with random gaps,
// in-bench isolation predictor and field-by-field result check
// depends on cia_pkg and the cone_isolation_accumulator rtl
`default_nettype none

module tb_cone_isolation_accumulator;
	import cia_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 250;
	localparam int PHASE_ITEMS   = 30;
	localparam int BURST_RUNS    = 10;
	localparam logic [23:0] SUM_SAT = 24'hFFFFFF;
	localparam int DR_FULL = 134217727;

	// one particle on the input stream
	typedef struct packed {
		req_kind_t          kind;
		logic signed [12:0] eta;
		logic [11:0]        phi;
		logic [15:0]        pt;
		logic               charged;
		logic [1:0]         vtx;
		logic               is_self;
		logic               last;
	} particle_t;

	// one isolation result
	typedef struct packed {
		logic [23:0] iso;
		logic [23:0] chg;
		logic [23:0] neu;
		logic [23:0] pu;
		logic        err;
	} iso_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// coord_eta, coord_phi, trans_momentum, is_charged, vertex_assoc, is_self
	logic [47:0] s_tdata = '0;
	// req_type
	logic s_tuser = 1'b0;
	// last_cand
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// isolation, charged_total, neutral_total, pileup_total
	logic [OUT_TDATA_W-1:0] m_tdata;
	// mode_error
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// stimulus and expected results
	particle_t   particle_q[$];
	iso_result_t iso_expected_q[$];
	particle_t   cur_particle;
	logic        took_item = 1'b0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_gap = 0;
	int rx_calm = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int mismatches = 0;

	// predictor copy of the registers and state
	logic [26:0]        cone_min = RST_MIN_DR_SQ;
	logic [26:0]        cone_max = RST_MAX_DR_SQ;
	logic [1:0]         mode_sel = RST_ISO_MODE;
	logic [15:0]        thr_neutral = RST_MIN_NEUTRAL_PT;
	logic [15:0]        thr_pileup = RST_MIN_PILEUP_PT;
	logic [8:0]         beta_w = RST_BETA_WEIGHT;
	logic signed [12:0] axis_eta = '0;
	logic [11:0]        axis_phi = '0;
	logic [23:0]        sum_charged = '0;
	logic [23:0]        sum_neutral = '0;
	logic [23:0]        sum_pileup = '0;

	cone_isolation_accumulator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// append to the pending stimulus
	function automatic void add_particle(particle_t p);
		particle_q.insert(particle_q.size(), p);
	endfunction

	function automatic logic [23:0] sat24(longint unsigned s);
		return (s > SUM_SAT) ? SUM_SAT : s[23:0];
	endfunction

	// cone test, sum update and result on the last candidate
	function automatic void isolation_step(particle_t p);
		longint deta, dphi, dr;
		longint unsigned plus, minus, term;
		logic [11:0] dphi_raw;
		iso_result_t r;
		if (p.kind == REQ_REFERENCE) begin
			axis_eta = p.eta;
			axis_phi = p.phi;
			sum_charged = '0;
			sum_neutral = '0;
			sum_pileup = '0;
			return;
		end
		if (!p.is_self) begin
			deta = longint'($signed(p.eta)) - longint'(axis_eta);
			dphi_raw = p.phi - axis_phi;
			dphi = longint'($signed(dphi_raw));
			dr = deta * deta + dphi * dphi;
			if (dr >= longint'(cone_min) && dr <= longint'(cone_max)) begin
				if (!p.charged) begin
					if (p.pt > thr_neutral)
						sum_neutral = sat24(sum_neutral + p.pt);
				end else if (p.vtx > 2'd1) begin
					sum_charged = sat24(sum_charged + p.pt);
				end else if (p.pt > thr_pileup) begin
					sum_pileup = sat24(sum_pileup + p.pt);
				end
			end
		end
		if (!p.last)
			return;
		r.iso = '0;
		r.err = 1'b0;
		if (mode_sel == MODE_CHARGED) begin
			r.iso = sum_charged;
		end else if (mode_sel == MODE_DELTA_BETA) begin
			plus = longint'(sum_neutral) << BETA_FRAC;
			minus = longint'(beta_w) * longint'(sum_pileup);
			term = (plus > minus) ? (plus - minus) >> BETA_FRAC : 0;
			r.iso = sat24(sum_charged + term);
		end else begin
			r.err = 1'b1;
		end
		r.chg = sum_charged;
		r.neu = sum_neutral;
		r.pu = sum_pileup;
		iso_expected_q.insert(iso_expected_q.size(), r);
		sum_charged = '0;
		sum_neutral = '0;
		sum_pileup = '0;
	endfunction

	function automatic particle_t mk(req_kind_t k, int eta, int phi, int pt, bit ch, int vtx,
			bit slf, bit last);
		particle_t p;
		p.kind = k;
		p.eta = eta[12:0];
		p.phi = phi[11:0];
		p.pt = pt[15:0];
		p.charged = ch;
		p.vtx = vtx[1:0];
		p.is_self = slf;
		p.last = last;
		return p;
	endfunction

	// mostly short gaps, a few long ones, and stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int rand_eta();
		case ($urandom_range(0, 7))
			0: return -4096 + int'($urandom_range(0, 3));
			1: return 4095 - int'($urandom_range(0, 3));
			default: return int'($urandom_range(0, 8191)) - 4096;
		endcase
	endfunction

	function automatic int rand_pt();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 64);
			4, 5, 6: return $urandom_range(0, 2000);
			7, 8: return $urandom_range(0, 65535);
			default: return 65535 - int'($urandom_range(0, 3));
		endcase
	endfunction

	// candidate scattered around the reference axis
	function automatic particle_t near_candidate(int aeta, int aphi, bit last);
		int span, e, f;
		case ($urandom_range(0, 3))
			0: span = 40;
			1: span = 200;
			2: span = 600;
			default: span = 0;
		endcase
		if (span == 0) begin
			e = rand_eta();
			f = $urandom_range(0, 4095);
		end else begin
			e = aeta + int'($urandom_range(0, 2 * span)) - span;
			f = aphi + int'($urandom_range(0, 2 * span)) - span;
			if (e < -4096 || e > 4095)
				e = rand_eta();
		end
		return mk(REQ_CANDIDATE, e, f, rand_pt(), 1'($urandom_range(0, 1)),
			$urandom_range(0, 3), $urandom_range(0, 15) == 0, last);
	endfunction

	// well-formed runs with random content, plus noise and broken runs
	task automatic queue_random_runs(int n_items);
		int added, run_len, aeta, aphi;
		bit last;
		added = 0;
		aeta = 0;
		aphi = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				add_particle(mk(req_kind_t'($urandom_range(0, 1)), $urandom, $urandom,
					$urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 3),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				added++;
			end else begin
				if ($urandom_range(0, 7) != 0) begin
					aeta = rand_eta();
					aphi = $urandom_range(0, 4095);
					add_particle(mk(REQ_REFERENCE, aeta, aphi, $urandom,
						1'($urandom_range(0, 1)), $urandom_range(0, 3),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					added++;
				end
				run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
					: $urandom_range(1, 8);
				for (int k = 0; k < run_len; k++) begin
					last = (k == run_len - 1) && ($urandom_range(0, 14) != 0);
					add_particle(near_candidate(aeta, aphi, last));
					added++;
				end
			end
		end
	endtask

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[26:0];
		case (idx)
			REG_MIN_DR_SQ:      cone_min = val[26:0];
			REG_MAX_DR_SQ:      cone_max = val[26:0];
			REG_ISO_MODE:       mode_sel = val[1:0];
			REG_MIN_NEUTRAL_PT: thr_neutral = val[15:0];
			REG_MIN_PILEUP_PT:  thr_pileup = val[15:0];
			REG_BETA_WEIGHT:    beta_w = val[8:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_cone(int dmin, int dmax, int mode, int nthr, int pthr, int beta);
		write_reg(REG_MIN_DR_SQ, dmin);
		write_reg(REG_MAX_DR_SQ, dmax);
		write_reg(REG_ISO_MODE, mode);
		write_reg(REG_MIN_NEUTRAL_PT, nthr);
		write_reg(REG_MIN_PILEUP_PT, pthr);
		write_reg(REG_BETA_WEIGHT, beta);
	endtask

	// sender idle until every result is back, then let the pipeline settle
	task automatic wait_drained();
		do
			@(posedge clk);
		while (particle_q.size() != 0 || s_tvalid || iso_expected_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string fname, logic [23:0] want, logic [23:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	// input driver: next particle after a transfer and its gap
	always @(negedge clk) begin
		particle_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || took_item) begin
			if (tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (particle_q.size() > 0) begin
				nxt = particle_q.pop_front();
				cur_particle <= nxt;
				s_tdata <= {3'b000, nxt.is_self, nxt.vtx, nxt.charged, nxt.pt, nxt.phi, nxt.eta};
				s_tuser <= nxt.kind;
				s_tlast <= nxt.last;
				s_tvalid <= 1'b1;
				tx_gap <= pick_gap(tx_calm);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// input transfer: run the predictor
	always @(posedge clk) begin
		took_item <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			isolation_step(cur_particle);
	end

	// result ready: random stalls and requested long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served < hold_requests) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else begin
			m_tready <= 1'b1;
			rx_gap <= pick_gap(rx_calm);
		end
	end

	// result transfer: compare with the oldest expected result
	always @(posedge clk) begin
		iso_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (iso_expected_q.size() == 0) begin
				$display("%0t: unexpected result, isolation %0d", $time, m_tdata[23:0]);
				mismatches++;
			end else begin
				want = iso_expected_q.pop_front();
				check_field("isolation", want.iso, m_tdata[23:0]);
				check_field("charged_total", want.chg, m_tdata[47:24]);
				check_field("neutral_total", want.neu, m_tdata[71:48]);
				check_field("pileup_total", want.pu, m_tdata[95:72]);
				check_field("mode_error", {23'b0, want.err}, {23'b0, m_tuser});
			end
		end
	end

	// stimulus sequence
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers: cone edges, thresholds, self skip, phi wrap, eta extremes
		add_particle(mk(REQ_REFERENCE, 0, 0, 65535, 1, 3, 1, 1));
		add_particle(mk(REQ_CANDIDATE, 100, 100, 500, 1, 3, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 4000, 65535, 1, 2, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 10, 10, 32, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 10, 4086, 33, 0, 1, 0, 0));
		add_particle(mk(REQ_CANDIDATE, -50, 50, 33, 1, 1, 0, 0));
		add_particle(mk(REQ_CANDIDATE, -50, 60, 32, 1, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 0, 1000, 1, 3, 1, 0));
		add_particle(mk(REQ_CANDIDATE, 200, 0, 700, 1, 3, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 0, 0, 1, 3, 1, 1));
		add_particle(mk(REQ_REFERENCE, 4095, 4095, 0, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 4095, 0, 7, 1, 3, 0, 1));
		add_particle(mk(REQ_REFERENCE, -4096, 0, 0, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, -4096, 4095, 9, 1, 2, 0, 1));
		add_particle(mk(REQ_CANDIDATE, 4095, 2048, 65535, 1, 3, 0, 1));
		wait_drained();

		// thin ring at r = 200, delta-beta with positive, negative and zero difference
		setup_cone(40000, 40000, MODE_DELTA_BETA, 0, 0, 256);
		add_particle(mk(REQ_REFERENCE, 0, 0, 0, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 200, 0, 1000, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 200, 300, 1, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, -200, 0, 50, 1, 3, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 199, 0, 5000, 1, 3, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 3896, 0, 0, 0, 0, 1));
		add_particle(mk(REQ_REFERENCE, 0, 0, 0, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 200, 0, 2000, 1, 1, 0, 0));
		add_particle(mk(REQ_CANDIDATE, -200, 0, 1000, 0, 0, 0, 1));
		add_particle(mk(REQ_REFERENCE, 0, 0, 0, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 200, 500, 1, 1, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 0, 3896, 500, 0, 3, 0, 1));
		wait_drained();

		// all three sums and the isolation run into saturation
		setup_cone(0, DR_FULL, MODE_DELTA_BETA, 0, 0, 0);
		add_particle(mk(REQ_REFERENCE, -4096, 0, 0, 0, 0, 0, 0));
		add_particle(mk(REQ_CANDIDATE, 4095, 2048, 65535, 1, 3, 0, 0));
		for (int k = 0; k < 780; k++)
			add_particle(mk(REQ_CANDIDATE, rand_eta(), $urandom, 65535 - (k % 2),
				(k % 3) != 1, (k % 3 == 0) ? 3 : 0, 0, k == 779));
		wait_drained();

		// random phases; a burst of one-candidate runs meets a long receiver hold-off
		setup_cone(0, 38000, MODE_DELTA_BETA, 32, 32, 128);
		add_particle(mk(REQ_REFERENCE, 0, 0, 0, 0, 0, 0, 0));
		for (int k = 0; k < BURST_RUNS; k++)
			add_particle(mk(REQ_CANDIDATE, k, k, 100 + k, 1, 3, 0, 1));
		queue_random_runs(PHASE_ITEMS);
		hold_requests++;
		wait_drained();

		setup_cone(0, DR_FULL, MODE_DELTA_BETA, 0, 0, 511);
		queue_random_runs(PHASE_ITEMS);
		wait_drained();

		setup_cone(100, 38000, 2, 65535, 65535, 256);
		queue_random_runs(PHASE_ITEMS);
		wait_drained();

		setup_cone(0, 0, 3, 16, 16, 0);
		queue_random_runs(PHASE_ITEMS);
		wait_drained();

		setup_cone($urandom_range(0, 2000), $urandom_range(2000, 200000), $urandom_range(0, 3),
			$urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 511));
		queue_random_runs(PHASE_ITEMS);
		wait_drained();

		setup_cone(DR_FULL, DR_FULL, MODE_CHARGED, 0, 65535, 1);
		queue_random_runs(PHASE_ITEMS);
		wait_drained();

		setup_cone(0, 60000, MODE_DELTA_BETA, 20, 40, 200);
		queue_random_runs(PHASE_ITEMS);
		wait_drained();

		if (mismatches == 0 && iso_expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
